### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define CHK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// implication form
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

### rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Types, constants and the divider step for the ray/triangle test.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int NUM_REGS = 8;
    localparam int DIV_BITS = 32;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_PER_STAGE;

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_T_LO  = 3'd6;
    localparam logic [2:0] REG_T_HI  = 3'd7;

    localparam logic signed [31:0] T_MAX_Q = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] T_MIN_Q = 32'sh8000_0000;

    typedef logic signed [15:0] coord_t;
    typedef logic signed [16:0] diff_t;

    typedef struct packed {
        coord_t ox, oy, oz;
        coord_t dx, dy, dz;
    } ray_t;

    typedef struct packed {
        logic vld;
        logic signed [50:0] det0, det1, det2;
        logic signed [50:0] nb0, nb1, nb2;
        logic signed [50:0] ng0, ng1, ng2;
        logic signed [51:0] nt0, nt1, nt2;
    } prod_t;

    typedef struct packed {
        logic        vld;
        logic        cond;
        logic        tneg;
        logic [52:0] det;
        logic [71:0] x;
    } quot_in_t;

    typedef struct packed {
        logic        vld;
        logic        cond;
        logic        tneg;
        logic        ovf;
        logic [52:0] det;
        logic [52:0] rem;
        logic [31:0] xlo;
        logic [31:0] q;
    } div_t;

    function automatic div_t div_step(div_t s);
        div_t        o;
        logic [53:0] r;
        o = s;
        for (int i = 0; i < DIV_PER_STAGE; i++)
        begin
            r = {o.rem, o.xlo[31]};
            o.xlo = {o.xlo[30:0], 1'b0};
            if (r >= {1'b0, o.det})
            begin
                r = r - {1'b0, o.det};
                o.q = {o.q[30:0], 1'b1};
            end
            else
            begin
                o.q = {o.q[30:0], 1'b0};
            end
            o.rem = r[52:0];
        end
        return o;
    endfunction

endpackage

### rtl/rti_geom.sv
// ----------------------------------------------------------------------------
// rti_geom
// Edge vectors, cross products and the Cramer products (three stages).
// ----------------------------------------------------------------------------
module rti_geom
    import rti_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [143:0]   in_data,
    input  ray_t           ray,
    output prod_t          prod
);

    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    assign ax = in_data[15:0];
    assign ay = in_data[31:16];
    assign az = in_data[47:32];
    assign bx = in_data[63:48];
    assign by = in_data[79:64];
    assign bz = in_data[95:80];
    assign cx = in_data[111:96];
    assign cy = in_data[127:112];
    assign cz = in_data[143:128];

    logic  s1_vld_reg, s2_vld_reg, s3_vld_reg;
    diff_t e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg, sx_reg, sy_reg, sz_reg;
    diff_t e1x2_reg, e1y2_reg, e1z2_reg, e2x2_reg, e2y2_reg, e2z2_reg;
    diff_t sx2_reg, sy2_reg, sz2_reg;
    logic signed [33:0] m0_reg, m1_reg, m2_reg;
    logic signed [34:0] p0_reg, p1_reg, p2_reg;
    prod_t pr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1x_reg <= 17'(ax) - 17'(bx);
            e1y_reg <= 17'(ay) - 17'(by);
            e1z_reg <= 17'(az) - 17'(bz);
            e2x_reg <= 17'(ax) - 17'(cx);
            e2y_reg <= 17'(ay) - 17'(cy);
            e2z_reg <= 17'(az) - 17'(cz);
            sx_reg  <= 17'(ax) - 17'(ray.ox);
            sy_reg  <= 17'(ay) - 17'(ray.oy);
            sz_reg  <= 17'(az) - 17'(ray.oz);

            m0_reg <= 34'(e2y_reg) * 34'(ray.dz) - 34'(ray.dy) * 34'(e2z_reg);
            m1_reg <= 34'(ray.dx) * 34'(e2z_reg) - 34'(e2x_reg) * 34'(ray.dz);
            m2_reg <= 34'(e2x_reg) * 34'(ray.dy) - 34'(e2y_reg) * 34'(ray.dx);
            p0_reg <= 35'(e1x_reg) * 35'(sy_reg) - 35'(sx_reg) * 35'(e1y_reg);
            p1_reg <= 35'(sx_reg) * 35'(e1z_reg) - 35'(e1x_reg) * 35'(sz_reg);
            p2_reg <= 35'(e1y_reg) * 35'(sz_reg) - 35'(sy_reg) * 35'(e1z_reg);
            e1x2_reg <= e1x_reg;
            e1y2_reg <= e1y_reg;
            e1z2_reg <= e1z_reg;
            e2x2_reg <= e2x_reg;
            e2y2_reg <= e2y_reg;
            e2z2_reg <= e2z_reg;
            sx2_reg  <= sx_reg;
            sy2_reg  <= sy_reg;
            sz2_reg  <= sz_reg;

            pr_reg.vld  <= 1'b0;
            pr_reg.det0 <= 51'(e1x2_reg) * 51'(m0_reg);
            pr_reg.det1 <= 51'(e1y2_reg) * 51'(m1_reg);
            pr_reg.det2 <= 51'(e1z2_reg) * 51'(m2_reg);
            pr_reg.nb0  <= 51'(sx2_reg) * 51'(m0_reg);
            pr_reg.nb1  <= 51'(sy2_reg) * 51'(m1_reg);
            pr_reg.nb2  <= 51'(sz2_reg) * 51'(m2_reg);
            pr_reg.ng0  <= 51'(ray.dz) * 51'(p0_reg);
            pr_reg.ng1  <= 51'(ray.dy) * 51'(p1_reg);
            pr_reg.ng2  <= 51'(ray.dx) * 51'(p2_reg);
            pr_reg.nt0  <= 52'(e2z2_reg) * 52'(p0_reg);
            pr_reg.nt1  <= 52'(e2y2_reg) * 52'(p1_reg);
            pr_reg.nt2  <= 52'(e2x2_reg) * 52'(p2_reg);
        end
    end

    always_comb
    begin
        prod     = pr_reg;
        prod.vld = s3_vld_reg;
    end

endmodule

### rtl/rti_reduce.sv
// ----------------------------------------------------------------------------
// rti_reduce
// Determinant and numerator sums, sign normalization, barycentric test and
// dividend setup for the floor quotient (three stages).
// ----------------------------------------------------------------------------
module rti_reduce
    import rti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  prod_t    prod,
    output quot_in_t qin
);

    logic s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic signed [52:0] det_reg, nb_reg, ng_reg;
    logic signed [53:0] nt_reg;
    logic               nz_reg;
    logic [52:0]        deta_reg;
    logic signed [53:0] nbn_reg, ngn_reg;
    logic signed [54:0] ntn_reg;
    quot_in_t           q_reg;

    logic [54:0] mag;
    logic        neg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_vld_reg <= prod.vld;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    assign neg = det_reg[52];
    assign mag = ntn_reg[54] ? 55'(-ntn_reg) : 55'(ntn_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= 53'(prod.det0) + 53'(prod.det1) + 53'(prod.det2);
            nb_reg  <= 53'(prod.nb0) + 53'(prod.nb1) + 53'(prod.nb2);
            ng_reg  <= 53'(prod.ng0) + 53'(prod.ng1) + 53'(prod.ng2);
            nt_reg  <= -(54'(prod.nt0) + 54'(prod.nt1) + 54'(prod.nt2));

            nz_reg   <= (det_reg != '0);
            deta_reg <= neg ? 53'(-det_reg) : 53'(det_reg);
            nbn_reg  <= neg ? -54'(nb_reg) : 54'(nb_reg);
            ngn_reg  <= neg ? -54'(ng_reg) : 54'(ng_reg);
            ntn_reg  <= neg ? -55'(nt_reg) : 55'(nt_reg);

            q_reg.vld  <= 1'b0;
            q_reg.cond <= nz_reg && !nbn_reg[53] && !ngn_reg[53]
                          && (nbn_reg <= $signed({1'b0, deta_reg}))
                          && (55'(nbn_reg) + 55'(ngn_reg) <= $signed({2'b0, deta_reg}));
            q_reg.tneg <= ntn_reg[54];
            q_reg.det  <= deta_reg;
            q_reg.x    <= {1'b0, mag[54:0], 16'b0}
                          + (ntn_reg[54] ? {19'b0, deta_reg - 53'd1} : 72'd0);
        end
    end

    always_comb
    begin
        qin     = q_reg;
        qin.vld = s6_vld_reg;
    end

endmodule

### rtl/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, two quotient bits per stage, with an
// overflow check ahead of the first step.
// ----------------------------------------------------------------------------
module rti_div
    import rti_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  quot_in_t qin,
    output div_t     qout
);

    div_t st_reg [DIV_STAGES+1];
    logic vld_reg [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= qin.vld;
            for (int i = 1; i <= DIV_STAGES; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].vld  <= 1'b0;
            st_reg[0].cond <= qin.cond;
            st_reg[0].tneg <= qin.tneg;
            st_reg[0].ovf  <= ({13'b0, qin.x[71:32]} >= qin.det);
            st_reg[0].det  <= qin.det;
            st_reg[0].rem  <= {13'b0, qin.x[71:32]};
            st_reg[0].xlo  <= qin.x[31:0];
            st_reg[0].q    <= '0;
            for (int i = 1; i <= DIV_STAGES; i++)
                st_reg[i] <= div_step(st_reg[i-1]);
        end
    end

    always_comb
    begin
        qout     = st_reg[DIV_STAGES];
        qout.vld = vld_reg[DIV_STAGES];
    end

endmodule

### rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Throughput: one triangle per cycle; the whole pipeline holds while the
// output register is full and m_tready is low.
// Reset: asynchronous, active low; clears valids and loads the ray registers
// (t_upper to the largest Q16.16 value, everything else to zero).
// ----------------------------------------------------------------------------
module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z (16 bits each)
    input  logic [143:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // hit [0], t_hit [32:1], zero pad [39:33]
    output logic [39:0]   m_tdata
);

    ray_t               ray_reg;
    logic signed [31:0] tlo_reg, thi_reg;
    logic               en;
    prod_t              prod;
    quot_in_t           qin;
    div_t               qout;
    logic               out_vld_reg;
    logic               hit_reg;
    logic signed [31:0] thit_reg;
    logic               sat;
    logic signed [31:0] tq;
    logic               hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg <= '0;
            tlo_reg <= '0;
            thi_reg <= T_MAX_Q;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORG_X: ray_reg.ox <= cfg_wdata[15:0];
                REG_ORG_Y: ray_reg.oy <= cfg_wdata[15:0];
                REG_ORG_Z: ray_reg.oz <= cfg_wdata[15:0];
                REG_DIR_X: ray_reg.dx <= cfg_wdata[15:0];
                REG_DIR_Y: ray_reg.dy <= cfg_wdata[15:0];
                REG_DIR_Z: ray_reg.dz <= cfg_wdata[15:0];
                REG_T_LO:  tlo_reg    <= cfg_wdata;
                REG_T_HI:  thi_reg    <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    rti_geom u_geom
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_tvalid),
        .in_data (s_tdata),
        .ray     (ray_reg),
        .prod    (prod)
    );

    rti_reduce u_reduce
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .prod  (prod),
        .qin   (qin)
    );

    rti_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .qin   (qin),
        .qout  (qout)
    );

    always_comb
    begin
        if (qout.tneg)
        begin
            sat = qout.ovf || (qout.q > 32'h8000_0000);
            tq  = sat ? T_MIN_Q : $signed(-qout.q);
        end
        else
        begin
            sat = qout.ovf || qout.q[31];
            tq  = sat ? T_MAX_Q : $signed(qout.q);
        end
        hit_next = qout.cond && (tq >= tlo_reg) && (tq <= thi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= qout.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            thit_reg <= hit_next ? tq : 32'sd0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, thit_reg, hit_reg};

endmodule

### rtl/rti_chk.sv
// ----------------------------------------------------------------------------
// rti_chk
// Port-level checks for ray_triangle_intersect, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rti_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `CHK_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    `CHK_IMPLY(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0)
    `CHK_IMPLY(a_pad_zero, m_tvalid, m_tdata[39:33] == 7'd0)
    `CHK_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready))

endmodule

bind ray_triangle_intersect rti_chk u_rti_chk (.*);
